### sv/cfsq_pkg.sv
// cfsq_pkg: shared widths, types, product index map and constant-multiply helpers
// for the radix 2^51 field squaring pipeline; no dependencies
`timescale 1ns / 1ps

package cfsq_pkg;

  // operand and result limb widths
  localparam int IN_W   = 52;
  localparam int LIMB_W = 51;
  localparam int NLIMB  = 5;

  // half-operand width for the partial products
  localparam int HALF_W = 26;
  localparam int PP_W   = 2 * HALF_W;
  localparam int PROD_W = 2 * IN_W;

  // column sums stay below 2^111, carries below 2^62
  localparam int COL_W  = 113;
  localparam int UP_W   = COL_W - LIMB_W;

  // final fold of the top carry times 19 into limb 0
  localparam int FOLD_W = UP_W + 5;
  localparam int FC_W   = FOLD_W - LIMB_W;

  // distinct products x_i * x_j with i <= j
  localparam int NPROD = 15;
  localparam int PAIR_A [NPROD] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 3, 3, 4};
  localparam int PAIR_B [NPROD] = '{0, 1, 2, 3, 4, 1, 2, 3, 4, 2, 3, 4, 3, 4, 4};

  localparam int P00 = 0;
  localparam int P01 = 1;
  localparam int P02 = 2;
  localparam int P03 = 3;
  localparam int P04 = 4;
  localparam int P11 = 5;
  localparam int P12 = 6;
  localparam int P13 = 7;
  localparam int P14 = 8;
  localparam int P22 = 9;
  localparam int P23 = 10;
  localparam int P24 = 11;
  localparam int P33 = 12;
  localparam int P34 = 13;
  localparam int P44 = 14;

  typedef logic [NLIMB-1:0][IN_W-1:0]   limbs_t;
  typedef logic [NPROD-1:0][PROD_W-1:0] prod_arr_t;
  typedef logic [NLIMB-1:0][COL_W-1:0]  col_arr_t;

  // result limbs, sq0 in the low bits
  typedef struct packed {
    logic [LIMB_W-1:0] sq4;
    logic [LIMB_W-1:0] sq3;
    logic [LIMB_W-1:0] sq2;
    logic [IN_W-1:0]   sq1;
    logic [LIMB_W-1:0] sq0;
  } result_t;

  // times 19 as shifts and adds
  function automatic logic [COL_W-1:0] mul19(input logic [COL_W-1:0] v);
    mul19 = (v << 4) + (v << 1) + v;
  endfunction

  // times 38 as shifts and adds
  function automatic logic [COL_W-1:0] mul38(input logic [COL_W-1:0] v);
    mul38 = (v << 5) + (v << 2) + (v << 1);
  endfunction

endpackage

### sv/curve25519_field_square.sv
// curve25519_field_square: top level of the pipelined squarer modulo 2^255-19
// in radix 2^51; depends on cfsq_pkg, cfsq_mul, cfsq_col and cfsq_carry
`timescale 1ns / 1ps

// Usage
//   in_*  : one request per operand, five 52-bit limbs packed in in_tdata,
//           accepted when in_tvalid and in_tready are both high.
//   out_* : one result per request, in request order, five result limbs
//           packed in out_tdata, taken when out_tvalid and out_tready are high.
// Pipeline: seven register stages (two for the limb products, one for the
//   column sums, four for the carry pass and final fold).
// Throughput: one request per cycle; the 26 x 26 partial product array is
//   fully pipelined, so nothing limits the rate but the receiver.
// Reset: rst_n low clears every stage valid bit; no request is in flight after.
// Stall: with out_tready low the last stage holds its result; each stage stays
//   ready while it or any stage after it is empty, so bubbles close up and in_tready
//   falls only once all seven stages hold a request.

module curve25519_field_square import cfsq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [263:0] in_tdata,   // limb0, limb1, limb2, limb3, limb4 (52 bits each), zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // sq0 (51), sq1 (52), sq2 (51), sq3 (51), sq4 (51)
);

  limbs_t    limbs;
  prod_arr_t prod;
  col_arr_t  col;
  result_t   res;
  logic      mul_valid, col_ready;
  logic      col_valid, carry_ready;

  // unpack operand limbs
  for (genvar i = 0; i < NLIMB; i++) begin : g_unpack
    assign limbs[i] = in_tdata[i*IN_W +: IN_W];
  end

  // limb products
  cfsq_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_limbs  (limbs),
    .out_valid (mul_valid),
    .out_ready (col_ready),
    .out_prod  (prod)
  );

  // column sums
  cfsq_col u_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (col_ready),
    .in_prod   (prod),
    .out_valid (col_valid),
    .out_ready (carry_ready),
    .out_col   (col)
  );

  // carry pass and fold
  cfsq_carry u_carry (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (col_valid),
    .in_ready  (carry_ready),
    .in_col    (col),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res;

endmodule

### sv/cfsq_mul.sv
// cfsq_mul: two pipeline stages that form the fifteen limb products x_i * x_j
// from 26 x 26 partial products; depends on cfsq_pkg
`timescale 1ns / 1ps

module cfsq_mul import cfsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  limbs_t    in_limbs,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_arr_t out_prod
);

  typedef logic [3:0][PP_W-1:0] pp_set_t;

  pp_set_t   pp_r   [NPROD];
  pp_set_t   pp_nxt [NPROD];
  prod_arr_t prod_r;
  prod_arr_t prod_nxt;
  logic      v1_r;
  logic      v2_r;
  logic      rdy1;
  logic      rdy2;

  // stage ready chain
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // partial products: ll, lh, hl, hh
  for (genvar p = 0; p < NPROD; p++) begin : g_pp
    logic [HALF_W-1:0] al, ah, bl, bh;
    assign al = in_limbs[PAIR_A[p]][HALF_W-1:0];
    assign ah = in_limbs[PAIR_A[p]][IN_W-1:HALF_W];
    assign bl = in_limbs[PAIR_B[p]][HALF_W-1:0];
    assign bh = in_limbs[PAIR_B[p]][IN_W-1:HALF_W];
    assign pp_nxt[p][0] = al * bl;
    assign pp_nxt[p][1] = al * bh;
    assign pp_nxt[p][2] = ah * bl;
    assign pp_nxt[p][3] = ah * bh;
  end

  // recombine the partial products
  for (genvar p = 0; p < NPROD; p++) begin : g_prod
    assign prod_nxt[p] = (PROD_W'(pp_r[p][3]) << PP_W)
                       + (PROD_W'(pp_r[p][1]) << HALF_W)
                       + (PROD_W'(pp_r[p][2]) << HALF_W)
                       + PROD_W'(pp_r[p][0]);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int p = 0; p < NPROD; p++) pp_r[p] <= pp_nxt[p];
    end
    if (rdy2 && v1_r) prod_r <= prod_nxt;
  end

  assign out_valid = v2_r;
  assign out_prod  = prod_r;

  // a product that can advance does so
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && rdy2 |=> v2_r)
    else $error("stage 1 request lost on advance");

endmodule

### sv/cfsq_col.sv
// cfsq_col: one pipeline stage that forms the five column sums of the square,
// with doubled cross terms and 19-folded high terms; depends on cfsq_pkg
`timescale 1ns / 1ps

module cfsq_col import cfsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_arr_t in_prod,
  output logic      out_valid,
  input  logic      out_ready,
  output col_arr_t  out_col
);

  col_arr_t col_r;
  col_arr_t col_nxt;
  logic     v_r;
  logic     rdy;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  function automatic logic [COL_W-1:0] ext(input logic [PROD_W-1:0] v);
    ext = COL_W'(v);
  endfunction

  // column sums
  always_comb begin
    col_nxt[0] = ext(in_prod[P00]) + mul38(ext(in_prod[P14]) + ext(in_prod[P23]));
    col_nxt[1] = (ext(in_prod[P01]) << 1) + mul19(ext(in_prod[P33]))
               + mul38(ext(in_prod[P24]));
    col_nxt[2] = (ext(in_prod[P02]) << 1) + ext(in_prod[P11])
               + mul38(ext(in_prod[P34]));
    col_nxt[3] = ((ext(in_prod[P03]) + ext(in_prod[P12])) << 1)
               + mul19(ext(in_prod[P44]));
    col_nxt[4] = ((ext(in_prod[P04]) + ext(in_prod[P13])) << 1) + ext(in_prod[P22]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) col_r <= col_nxt;
  end

  assign out_valid = v_r;
  assign out_col   = col_r;

  // the largest column stays below 2^111
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> col_r[0][COL_W-1:COL_W-2] == 2'b00)
    else $error("column 0 exceeds its bound");

endmodule

### sv/cfsq_carry.sv
// cfsq_carry: four pipeline stages for the 51-bit carry pass, the fold of the
// top carry times 19 into limb 0 and the last carry into limb 1; depends on cfsq_pkg
`timescale 1ns / 1ps

module cfsq_carry import cfsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  col_arr_t in_col,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  // stage 4: columns 0 and 1
  logic [LIMB_W-1:0] s4_l0_r, s4_l1_r;
  logic [UP_W-1:0]   s4_u1_r;
  logic [COL_W-1:0]  s4_c2_r, s4_c3_r, s4_c4_r;
  // stage 5: columns 2 and 3
  logic [LIMB_W-1:0] s5_l0_r, s5_l1_r, s5_l2_r, s5_l3_r;
  logic [UP_W-1:0]   s5_u3_r;
  logic [COL_W-1:0]  s5_c4_r;
  // stage 6: column 4
  logic [LIMB_W-1:0] s6_l0_r, s6_l1_r, s6_l2_r, s6_l3_r, s6_l4_r;
  logic [UP_W-1:0]   s6_u4_r;
  // stage 7: fold and final carry
  result_t           res_r;
  result_t           res_nxt;

  logic [COL_W-1:0]  c1_nxt, c2_nxt, c3_nxt, c4_nxt;
  logic [FOLD_W-1:0] fold_nxt;
  logic              v4_r, v5_r, v6_r, v7_r;
  logic              rdy4, rdy5, rdy6, rdy7;

  // stage ready chain
  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  // carry adds
  assign c1_nxt = in_col[1] + COL_W'(in_col[0][COL_W-1:LIMB_W]);
  assign c2_nxt = s4_c2_r + COL_W'(s4_u1_r);
  assign c3_nxt = s4_c3_r + COL_W'(c2_nxt[COL_W-1:LIMB_W]);
  assign c4_nxt = s5_c4_r + COL_W'(s5_u3_r);

  // top carry times 19 back into limb 0, then carry into limb 1
  assign fold_nxt = FOLD_W'(s6_l0_r) + (FOLD_W'(s6_u4_r) << 4)
                  + (FOLD_W'(s6_u4_r) << 1) + FOLD_W'(s6_u4_r);

  always_comb begin
    res_nxt.sq0 = fold_nxt[LIMB_W-1:0];
    res_nxt.sq1 = IN_W'(s6_l1_r) + IN_W'(fold_nxt[FOLD_W-1:LIMB_W]);
    res_nxt.sq2 = s6_l2_r;
    res_nxt.sq3 = s6_l3_r;
    res_nxt.sq4 = s6_l4_r;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      s4_l0_r <= in_col[0][LIMB_W-1:0];
      s4_l1_r <= c1_nxt[LIMB_W-1:0];
      s4_u1_r <= c1_nxt[COL_W-1:LIMB_W];
      s4_c2_r <= in_col[2];
      s4_c3_r <= in_col[3];
      s4_c4_r <= in_col[4];
    end
    if (rdy5 && v4_r) begin
      s5_l0_r <= s4_l0_r;
      s5_l1_r <= s4_l1_r;
      s5_l2_r <= c2_nxt[LIMB_W-1:0];
      s5_l3_r <= c3_nxt[LIMB_W-1:0];
      s5_u3_r <= c3_nxt[COL_W-1:LIMB_W];
      s5_c4_r <= s4_c4_r;
    end
    if (rdy6 && v5_r) begin
      s6_l0_r <= s5_l0_r;
      s6_l1_r <= s5_l1_r;
      s6_l2_r <= s5_l2_r;
      s6_l3_r <= s5_l3_r;
      s6_l4_r <= c4_nxt[LIMB_W-1:0];
      s6_u4_r <= c4_nxt[COL_W-1:LIMB_W];
    end
    if (rdy7 && v6_r) res_r <= res_nxt;
  end

  assign out_valid = v7_r;
  assign out_res   = res_r;

  // carries out of columns 3 and 4 stay below 2^60
  a_u3_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> s5_u3_r[UP_W-1:UP_W-2] == 2'b00)
    else $error("carry out of column 3 too large");

  a_u4_range: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> s6_u4_r[UP_W-1:UP_W-2] == 2'b00)
    else $error("carry out of column 4 too large");

endmodule
